@@ rtl/core/ewsc_pkg.sv @@
// ---------------------------------------------------------------------------
// ewsc_pkg: word shape checker types and letter tables
// Constants, letter codes and onset/coda lookup functions.
// ---------------------------------------------------------------------------
`default_nettype none
package ewsc_pkg;

  localparam int LETTER_W = 5;
  typedef logic [LETTER_W-1:0] letter_t;

  localparam letter_t L_A = 5'd0;
  localparam letter_t L_H = 5'd7;
  localparam letter_t L_J = 5'd9;
  localparam letter_t L_Q = 5'd16;
  localparam letter_t L_S = 5'd18;
  localparam letter_t L_V = 5'd21;
  localparam letter_t L_X = 5'd23;

  function automatic letter_t lc(input byte unsigned c);
    letter_t r;
    r = LETTER_W'(c - 8'h61);
    return r;
  endfunction

  // t holds the pattern as packed ASCII, first letter in the top byte
  function automatic logic eq2(input letter_t a, input letter_t b, input logic [15:0] t);
    logic r;
    r = (a == lc(t[15:8])) && (b == lc(t[7:0]));
    return r;
  endfunction

  function automatic logic onset2_ok(input letter_t a, input letter_t b);
    logic r;
    r = eq2(a,b,"bl")|eq2(a,b,"br")|eq2(a,b,"ch")|eq2(a,b,"cl")|eq2(a,b,"cr")|
        eq2(a,b,"dr")|eq2(a,b,"dw")|eq2(a,b,"fl")|eq2(a,b,"fr")|eq2(a,b,"gl")|
        eq2(a,b,"gr")|eq2(a,b,"gh")|eq2(a,b,"kn")|eq2(a,b,"ph")|eq2(a,b,"pl")|
        eq2(a,b,"pr")|eq2(a,b,"sc")|eq2(a,b,"sh")|eq2(a,b,"sk")|eq2(a,b,"sl")|
        eq2(a,b,"sm")|eq2(a,b,"sn")|eq2(a,b,"sp")|eq2(a,b,"st")|eq2(a,b,"sw")|
        eq2(a,b,"th")|eq2(a,b,"tr")|eq2(a,b,"tw")|eq2(a,b,"wh")|eq2(a,b,"wr");
    return r;
  endfunction

  function automatic logic eq3(input letter_t a, input letter_t b, input letter_t c,
                               input logic [23:0] t);
    logic r;
    r = (a == lc(t[23:16])) && (b == lc(t[15:8])) && (c == lc(t[7:0]));
    return r;
  endfunction

  function automatic logic onset3_ok(input letter_t a, input letter_t b, input letter_t c);
    logic r;
    r = eq3(a,b,c,"chr")|eq3(a,b,c,"scr")|eq3(a,b,c,"spl")|eq3(a,b,c,"spr")|
        eq3(a,b,c,"str")|eq3(a,b,c,"thr")|eq3(a,b,c,"sph");
    return r;
  endfunction

  function automatic logic coda2_ok(input letter_t a, input letter_t b);
    logic r;
    r = eq2(a,b,"bs")|eq2(a,b,"ch")|eq2(a,b,"ck")|eq2(a,b,"ct")|eq2(a,b,"ds")|
        eq2(a,b,"ff")|eq2(a,b,"ft")|eq2(a,b,"gg")|eq2(a,b,"gh")|eq2(a,b,"gs")|
        eq2(a,b,"ld")|eq2(a,b,"lf")|eq2(a,b,"lk")|eq2(a,b,"ll")|eq2(a,b,"lm")|
        eq2(a,b,"lp")|eq2(a,b,"lt")|eq2(a,b,"mb")|eq2(a,b,"mp")|eq2(a,b,"ms")|
        eq2(a,b,"nd")|eq2(a,b,"ng")|eq2(a,b,"nk")|eq2(a,b,"nl")|eq2(a,b,"ns")|
        eq2(a,b,"nt")|eq2(a,b,"ny")|eq2(a,b,"nx")|eq2(a,b,"ph")|eq2(a,b,"pt")|
        eq2(a,b,"rd")|eq2(a,b,"rf")|eq2(a,b,"rg")|eq2(a,b,"rk")|eq2(a,b,"rl")|
        eq2(a,b,"rm")|eq2(a,b,"rn")|eq2(a,b,"rp")|eq2(a,b,"rs")|eq2(a,b,"rt")|
        eq2(a,b,"rv")|eq2(a,b,"rx")|eq2(a,b,"ry")|eq2(a,b,"sh")|eq2(a,b,"sk")|
        eq2(a,b,"sp")|eq2(a,b,"ss")|eq2(a,b,"st")|eq2(a,b,"th")|eq2(a,b,"ts")|
        eq2(a,b,"tt")|eq2(a,b,"tz")|eq2(a,b,"wd")|eq2(a,b,"wn")|eq2(a,b,"xt");
    return r;
  endfunction

  function automatic logic coda3_ok(input letter_t a, input letter_t b, input letter_t c);
    logic r;
    r = eq3(a,b,c,"cts")|eq3(a,b,c,"dge")|eq3(a,b,c,"ght")|eq3(a,b,c,"gth")|
        eq3(a,b,c,"lch")|eq3(a,b,c,"ldy")|eq3(a,b,c,"lsh")|eq3(a,b,c,"lts")|
        eq3(a,b,c,"mps")|eq3(a,b,c,"nch")|eq3(a,b,c,"ndy")|eq3(a,b,c,"ngs")|
        eq3(a,b,c,"nks")|eq3(a,b,c,"nst")|eq3(a,b,c,"nts")|eq3(a,b,c,"rch")|
        eq3(a,b,c,"rds")|eq3(a,b,c,"rgs")|eq3(a,b,c,"rks")|eq3(a,b,c,"rld")|
        eq3(a,b,c,"rms")|eq3(a,b,c,"rns")|eq3(a,b,c,"rps")|eq3(a,b,c,"rse")|
        eq3(a,b,c,"rst")|eq3(a,b,c,"rth")|eq3(a,b,c,"rts")|eq3(a,b,c,"rve")|
        eq3(a,b,c,"shs")|eq3(a,b,c,"sks")|eq3(a,b,c,"sps")|eq3(a,b,c,"sts")|
        eq3(a,b,c,"ths")|eq3(a,b,c,"xth");
    return r;
  endfunction

  function automatic logic eq4(input letter_t a, input letter_t b, input letter_t c,
                               input letter_t d, input logic [31:0] t);
    logic r;
    r = eq2(a,b,t[31:16]) && eq2(c,d,t[15:0]);
    return r;
  endfunction

  function automatic logic coda4_ok(input letter_t a, input letter_t b, input letter_t c,
                                    input letter_t d);
    logic r;
    r = eq4(a,b,c,d,"ghts")|eq4(a,b,c,d,"gths")|eq4(a,b,c,d,"ldst")|
        eq4(a,b,c,d,"ngth")|eq4(a,b,c,d,"rths")|eq4(a,b,c,d,"stts")|
        ((d == L_S) && coda3_ok(a,b,c));
    return r;
  endfunction

  function automatic logic coda1_ok(input letter_t a);
    logic r;
    r = (a != L_H) && (a != L_J) && (a != L_Q) && (a != L_V);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ewsc_run_check.sv @@
// ---------------------------------------------------------------------------
// ewsc_run_check: consonant run shape check
// Checks a buffered consonant run as onset, coda, or coda+onset split.
// ---------------------------------------------------------------------------
`default_nettype none
module ewsc_run_check #(
  parameter int BUF = 7,
  parameter int LW  = 4
) (
  input  wire ewsc_pkg::letter_t letters [BUF],
  input  wire logic [LW-1:0]     run_len,
  output logic                   onset_ok,
  output logic                   coda_ok,
  output logic                   split_ok
);

  logic [BUF:0] on_sfx;   // on_sfx[i]: letters[i..n-1] is an onset
  logic [BUF:0] co_pfx;   // co_pfx[i]: letters[0..i-1] is a coda
  ewsc_pkg::letter_t l [BUF+3];

  always_comb begin
    for (int k = 0; k < BUF + 3; k++) begin
      l[k] = (k < BUF) ? letters[k] : ewsc_pkg::L_A;
    end
    for (int i = 0; i <= BUF; i++) begin
      priority if (int'(run_len) == i) begin
        on_sfx[i] = 1'b1;
      end else if (int'(run_len) == i + 1) begin
        on_sfx[i] = (l[i] != ewsc_pkg::L_X);
      end else if (int'(run_len) == i + 2) begin
        on_sfx[i] = ewsc_pkg::onset2_ok(l[i], l[i+1]);
      end else if (int'(run_len) == i + 3) begin
        on_sfx[i] = ewsc_pkg::onset3_ok(l[i], l[i+1], l[i+2]);
      end else begin
        on_sfx[i] = 1'b0;
      end
    end
    co_pfx = '0;
    co_pfx[0] = 1'b1;
    co_pfx[1] = ewsc_pkg::coda1_ok(l[0]);
    co_pfx[2] = ewsc_pkg::coda2_ok(l[0], l[1]);
    co_pfx[3] = ewsc_pkg::coda3_ok(l[0], l[1], l[2]);
    co_pfx[4] = ewsc_pkg::coda4_ok(l[0], l[1], l[2], l[3]);
    onset_ok = 1'b0;
    coda_ok  = 1'b0;
    split_ok = 1'b0;
    if (int'(run_len) <= BUF) begin
      onset_ok = on_sfx[0];
      for (int i = 0; i <= BUF; i++) begin
        if (int'(run_len) == i) coda_ok = co_pfx[i];
        if (i <= int'(run_len) && co_pfx[i] && on_sfx[i]) split_ok = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/english_word_shape_checker.sv @@
// ---------------------------------------------------------------------------
// english_word_shape_checker: streaming English word shape verdict
// Takes one byte per request and returns one verdict per word.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one byte of a word per request, in_tlast on the
//   final byte. Output channel out_*: one verdict per word (out_tdata[0] is
//   is_word), given for the request that carried in_tlast.
//   The verdict is registered in the output register when the last byte is taken.
//   Throughput: one byte per cycle; all split points of a closing consonant
//   run are checked in parallel by constant table logic in ewsc_run_check.
//   Stall: while a verdict waits in the output register, bytes without
//   tlast keep flowing; a last byte is held off only if the output
//   register stays full at that edge.
//   Reset: rst_n (synchronous, low) clears the word state and empties the
//   output register. Letter buffer contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none
module english_word_shape_checker #(
  parameter int MAX_WORD_LENGTH  = 25,
  parameter int MAX_VOWEL_RUN    = 3,
  parameter int CONSONANT_BUFFER = 7
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_byte
  input  wire logic       in_tlast,   // last_char
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] is_word, [7:1] zero
);

  localparam int RLW = $clog2(CONSONANT_BUFFER + 2);
  localparam int CIW = (CONSONANT_BUFFER > 1) ? $clog2(CONSONANT_BUFFER) : 1;

  logic [4:0]      letters_seen_r, letters_seen_nxt;
  logic            word_failed_r, word_failed_nxt;
  logic            in_vowel_run_r, in_vowel_run_nxt;
  logic            first_open_r, first_open_nxt;
  logic [2:0]      vowel_len_r, vowel_len_nxt;
  logic [RLW-1:0]  cons_len_r, cons_len_nxt;
  ewsc_pkg::letter_t cons_r [CONSONANT_BUFFER];
  logic            out_valid_r;
  logic            is_word_r, is_word_nxt;

  logic            accept;
  logic [7:0]      ch;
  logic            is_letter, is_vowel;
  ewsc_pkg::letter_t li;
  logic            on_ok, co_ok, sp_ok;

  assign in_tready  = !out_valid_r || out_tready || !in_tlast;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, is_word_r};

  ewsc_run_check #(.BUF(CONSONANT_BUFFER), .LW(RLW)) u_run (
    .letters (cons_r),
    .run_len (cons_len_r),
    .onset_ok(on_ok),
    .coda_ok (co_ok),
    .split_ok(sp_ok)
  );

  always_comb begin
    ch = ((in_tdata >= 8'h41) && (in_tdata <= 8'h5a)) ? in_tdata + 8'h20 : in_tdata;
    is_letter = (ch >= 8'h61) && (ch <= 8'h7a);
    li = ewsc_pkg::letter_t'(ch - 8'h61);
    is_vowel = (ch == 8'h61) || (ch == 8'h65) || (ch == 8'h69) || (ch == 8'h6f) ||
               (ch == 8'h75) || (ch == 8'h79);
    letters_seen_nxt = letters_seen_r;
    word_failed_nxt  = word_failed_r;
    in_vowel_run_nxt = in_vowel_run_r;
    first_open_nxt   = first_open_r;
    vowel_len_nxt    = vowel_len_r;
    cons_len_nxt     = cons_len_r;
    if (int'(letters_seen_r) >= MAX_WORD_LENGTH) word_failed_nxt = 1'b1;
    else letters_seen_nxt = letters_seen_r + 5'd1;
    if (!is_letter) begin
      word_failed_nxt = 1'b1;
    end else if (is_vowel) begin
      if (!in_vowel_run_r) begin
        if (cons_len_r != '0 && !(first_open_r ? on_ok : sp_ok)) word_failed_nxt = 1'b1;
        cons_len_nxt = '0;
        vowel_len_nxt = '0;
      end
      in_vowel_run_nxt = 1'b1;
      first_open_nxt = 1'b0;
      if (vowel_len_nxt < 3'd7) vowel_len_nxt = vowel_len_nxt + 3'd1;
      if (int'(vowel_len_nxt) > MAX_VOWEL_RUN) word_failed_nxt = 1'b1;
    end else begin
      in_vowel_run_nxt = 1'b0;
      vowel_len_nxt = '0;
      if (int'(cons_len_r) <= CONSONANT_BUFFER) cons_len_nxt = cons_len_r + RLW'(1);
    end
    // the verdict itself comes from the updated-run checker below
    is_word_nxt = 1'b0;
    if (in_tlast) begin
      letters_seen_nxt = '0;
      word_failed_nxt  = 1'b0;
      in_vowel_run_nxt = 1'b0;
      first_open_nxt   = 1'b1;
      vowel_len_nxt    = '0;
      cons_len_nxt     = '0;
    end
  end

  // Last byte verdict: the closing run includes this byte when it is a
  // consonant, so evaluate a second checker on the updated buffer.
  ewsc_pkg::letter_t cons_upd [CONSONANT_BUFFER];
  logic [RLW-1:0]    len_upd;
  logic              fail_upd, first_upd;
  logic              u_on, u_co, u_sp;
  logic              is_word_nxt_fin;

  always_comb begin
    for (int k = 0; k < CONSONANT_BUFFER; k++) begin
      cons_upd[k] = cons_r[k];
    end
    len_upd = cons_len_r;
    fail_upd = word_failed_r;
    first_upd = first_open_r;
    if (int'(letters_seen_r) >= MAX_WORD_LENGTH) fail_upd = 1'b1;
    if (!is_letter) begin
      fail_upd = 1'b1;
    end else if (is_vowel) begin
      if (!in_vowel_run_r && cons_len_r != '0 && !(first_open_r ? on_ok : sp_ok))
        fail_upd = 1'b1;
      len_upd = '0;
      first_upd = 1'b0;
      // a saturated vowel count stays put and cannot newly exceed the limit
      if (!in_vowel_run_r) begin
        if (MAX_VOWEL_RUN < 1) fail_upd = 1'b1;
      end else if (int'(vowel_len_r) >= MAX_VOWEL_RUN && vowel_len_r != 3'd7) begin
        fail_upd = 1'b1;
      end
    end else begin
      if (int'(cons_len_r) < CONSONANT_BUFFER) cons_upd[cons_len_r[CIW-1:0]] = li;
      if (int'(cons_len_r) <= CONSONANT_BUFFER) len_upd = cons_len_r + RLW'(1);
    end
  end

  ewsc_run_check #(.BUF(CONSONANT_BUFFER), .LW(RLW)) u_fin (
    .letters (cons_upd),
    .run_len (len_upd),
    .onset_ok(u_on),
    .coda_ok (u_co),
    .split_ok(u_sp)
  );

  assign is_word_nxt_fin = !fail_upd && (len_upd == '0 || (first_upd ? u_on : u_co));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letters_seen_r <= '0;
      word_failed_r  <= 1'b0;
      in_vowel_run_r <= 1'b0;
      first_open_r   <= 1'b1;
      vowel_len_r    <= '0;
      cons_len_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        letters_seen_r <= letters_seen_nxt;
        word_failed_r  <= word_failed_nxt;
        in_vowel_run_r <= in_vowel_run_nxt;
        first_open_r   <= first_open_nxt;
        vowel_len_r    <= vowel_len_nxt;
        cons_len_r     <= cons_len_nxt;
      end
      if (accept && in_tlast) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_letter && !is_vowel && int'(cons_len_r) < CONSONANT_BUFFER)
      cons_r[cons_len_r[CIW-1:0]] <= li;
    if (accept && in_tlast) is_word_r <= is_word_nxt_fin || is_word_nxt;
  end

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(accept && in_tlast))
    else $error("verdict overwritten while stalled");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> (cons_len_r == '0) && first_open_r && !word_failed_r)
    else $error("word state not cleared");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cons_len_r) <= CONSONANT_BUFFER + 1)
    else $error("consonant run length overflow");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: english_word_shape_checker testbench
// Streams bytes of words into the checker and compares each verdict with a
// local word shape predictor, under several idle and stall patterns.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_MAX  = 25;
  localparam int VOWEL_MAX = 3;
  localparam int CBUF      = 7;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {MODE_ONSET, MODE_CODA, MODE_SPLIT} run_mode_t;

  typedef struct {
    byte unsigned ch;
    bit           last;
    int           verdict; // -1: predictor decides
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  english_word_shape_checker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // predictor word state
  int      w_len;
  bit      w_bad;
  bit      w_in_vowel;
  bit      w_first_open;
  int      w_vrun;
  ewsc_pkg::letter_t w_cons [CBUF];
  int      w_crun;

  bit   verdict_q [$];
  int   fail_cnt = 0;
  int   cycle_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;
  bit   stim_done = 1'b0;

  byte unsigned word_buf [$];
  dir_row_t dir_tab [$];

  function automatic bit in_tab(string tab, int n, ewsc_pkg::letter_t s [CBUF], int off);
    bit same;
    for (int p = 0; p < tab.len(); p += n) begin
      same = 1'b1;
      for (int k = 0; k < n; k++)
        if (ewsc_pkg::letter_t'(tab[p+k] - 8'h61) != s[off+k]) same = 1'b0;
      if (same) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit onset_fits(ewsc_pkg::letter_t s [CBUF], int off, int n);
    if (n == 0) return 1'b1;
    if (n == 1) return s[off] != ewsc_pkg::L_X;
    if (n == 2) return in_tab({"blbrchclcrdrdwflfrglgrghknphplprscshskslsmsnspstsw",
                               "thtrtwwhwr"}, 2, s, off);
    if (n == 3) return in_tab("chrscrsplsprstrthrsph", 3, s, off);
    return 1'b0;
  endfunction

  function automatic bit coda_fits(ewsc_pkg::letter_t s [CBUF], int n);
    string c3;
    c3 = {"ctsdgeghtgthlchldylshltsmpsnchndyngsnksnstntsrchrdsrgsrks",
          "rldrmsrnsrpsrserstrthrtsrveshsskssspsststhsxth"};
    if (n == 0) return 1'b1;
    if (n == 1) return s[0] != ewsc_pkg::L_H && s[0] != ewsc_pkg::L_J &&
                       s[0] != ewsc_pkg::L_Q && s[0] != ewsc_pkg::L_V;
    if (n == 2) return in_tab({"bschckctdsffftggghgsldlflklllmlpltmbmpmsndngnknlns",
                               "ntnynxphptrdrfrgrkrlrmrnrprsrtrvrxryshskspssstthts",
                               "tttzwdwnxt"}, 2, s, 0);
    if (n == 3) return in_tab(c3, 3, s, 0);
    if (n == 4) return in_tab("ghtsgthsldstngthrthsstts", 4, s, 0) ||
                       (s[3] == ewsc_pkg::L_S && in_tab(c3, 3, s, 0));
    return 1'b0;
  endfunction

  function automatic bit run_fits(run_mode_t m);
    if (w_crun > CBUF) return 1'b0;
    if (m == MODE_ONSET) return onset_fits(w_cons, 0, w_crun);
    if (m == MODE_CODA) return coda_fits(w_cons, w_crun);
    for (int i = 0; i <= w_crun; i++)
      if (coda_fits(w_cons, i) && onset_fits(w_cons, i, w_crun - i)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_word();
    w_len = 0; w_bad = 0; w_in_vowel = 0; w_first_open = 1; w_vrun = 0; w_crun = 0;
  endfunction

  // advance the word state by one byte; queue a verdict on the last byte
  function automatic void shape_step(byte unsigned ch, bit last);
    byte unsigned c;
    bit ok;
    c = ch;
    if (w_len >= WORD_MAX) w_bad = 1; else w_len++;
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    if (c < "a" || c > "z") begin
      w_bad = 1;
    end else if (c == "a" || c == "e" || c == "i" || c == "o" || c == "u" || c == "y") begin
      if (!w_in_vowel) begin
        if (w_crun > 0 && !run_fits(w_first_open ? MODE_ONSET : MODE_SPLIT)) w_bad = 1;
        w_crun = 0;
        w_vrun = 0;
      end
      w_in_vowel = 1;
      w_first_open = 0;
      if (w_vrun < 7) w_vrun++;
      if (w_vrun > VOWEL_MAX) w_bad = 1;
    end else begin
      w_in_vowel = 0;
      w_vrun = 0;
      if (w_crun < CBUF) w_cons[w_crun] = ewsc_pkg::letter_t'(c - 8'h61);
      if (w_crun <= CBUF) w_crun++;
    end
    if (last) begin
      ok = !w_bad;
      if (w_crun > 0 && !run_fits(w_first_open ? MODE_ONSET : MODE_CODA)) ok = 0;
      verdict_q = {verdict_q, ok};
      clear_word();
    end
  endfunction

  task automatic send_byte(byte unsigned ch, bit last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shape_step(ch, last);
  endtask

  task automatic send_word();
    for (int i = 0; i < word_buf.size(); i++)
      send_byte(word_buf[i], i == word_buf.size() - 1);
  endtask

  function automatic byte unsigned rand_letter(bit vowel);
    byte unsigned v [6] = '{"a", "e", "i", "o", "u", "y"};
    byte unsigned c;
    if (vowel) c = v[$urandom_range(5)];
    else begin
      do c = 8'(8'h61 + $urandom_range(25));
      while (c == "a" || c == "e" || c == "i" || c == "o" || c == "u" || c == "y");
    end
    if ($urandom_range(9) == 0) c = c - 8'd32;
    return c;
  endfunction

  // mostly plausible words from real clusters, with some noise
  task automatic build_word();
    string clus [] = '{"", "b", "st", "str", "chr", "sph", "ght", "ghts", "rst",
                       "rsts", "ngth", "ntstr", "ldstr", "x", "nx", "ck", "rth",
                       "th", "sh", "spl", "mpsp", "dge", "rsts"};
    int nseg;
    string cl;
    word_buf.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 30)) word_buf = {word_buf, 8'($urandom_range(255))};
      return;
    end
    nseg = $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 9)) word_buf = {word_buf, rand_letter(0)};
      else begin
        cl = clus[$urandom_range(clus.size() - 1)];
        for (int k = 0; k < cl.len(); k++) word_buf = {word_buf, cl[k]};
      end
      repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 6 : 2))
        word_buf = {word_buf, rand_letter(1)};
    end
    if ($urandom_range(1)) begin
      cl = clus[$urandom_range(clus.size() - 1)];
      for (int k = 0; k < cl.len(); k++) word_buf = {word_buf, cl[k]};
    end
    if ($urandom_range(19) == 0)
      word_buf.insert($urandom_range(word_buf.size()), 8'($urandom_range(255)));
    if (word_buf.size() == 0) word_buf = {word_buf, rand_letter(0)};
  endtask

  task automatic add_dir(string w, int verdict);
    dir_row_t r;
    for (int i = 0; i < w.len(); i++) begin
      r.ch = w[i]; r.last = (i == w.len() - 1); r.verdict = r.last ? verdict : -1;
      dir_tab = {dir_tab, r};
    end
  endtask

  // stimulus
  initial begin
    int sent;
    int n_dir;
    dir_row_t r;
    clear_word();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_dir("STRAY", 1);      // upper case folds, three-letter onset
    add_dir("aeio", 0);       // vowel run too long
    add_dir("brrr", -1);      // whole word is consonants: onset rule
    add_dir("x", 0);
    add_dir("ghts", 0);
    add_dir("a@", 0);         // non-letter byte
    add_dir({"a", 8'hff}, 0);
    // null byte as a one-byte word
    r.ch = 8'h00; r.last = 1'b1; r.verdict = 0;
    dir_tab = {dir_tab, r};
    add_dir("oghts", 1);      // four-letter coda
    add_dir("arsts", 1);      // three-letter coda plus s
    add_dir("abcdfghjka", 0); // consonant run saturates
    add_dir("aaazaaazaaazaaazaaazaaaza", -1);  // exactly the length limit
    add_dir("aaazaaazaaazaaazaaazaaazab", 0);  // one too long
    add_dir("instra", -1);    // coda plus onset split
    add_dir("z", -1);
    n_dir = dir_tab.size();
    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.last && r.verdict >= 0) begin
        send_byte(r.ch, r.last);
        if (verdict_q[$] != bit'(r.verdict)) begin
          $error("is_word table row %0d: expected %0d, predictor %0d",
                 i, r.verdict, verdict_q[$]);
          fail_cnt++;
        end
      end else send_byte(r.ch, r.last);
    end

    sent = n_dir;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        3: begin send_idle_pct = 18; recv_stall_pct = 18; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b1; end
      endcase
      while (sent < n_dir + (ph + 1) * 260) begin
        build_word();
        send_word();
        sent += word_buf.size();
      end
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int hold_cnt;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_cnt = 0;
        out_tready <= 1'b0;
        while (hold_cnt < 300) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_off = 1'b0;
      end
      out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // verdict check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("is_word: no verdict expected, actual %0d", out_tdata[0]);
        fail_cnt++;
      end else begin
        if (out_tdata[0] != verdict_q[0]) begin
          $error("is_word: expected %0d, actual %0d", verdict_q[0], out_tdata[0]);
          fail_cnt++;
        end
        if (out_tdata[7:1] != 7'd0) begin
          $error("pad: expected 0, actual %0h", out_tdata[7:1]);
          fail_cnt++;
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  // end of run and timeout
  initial begin
    int tail;
    tail = 0;
    while (!(stim_done && verdict_q.size() == 0) && cycle_cnt < CYCLE_LIMIT)
      @(posedge clk);
    while (tail < 10 && cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      tail++;
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
    end else if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

endmodule
`default_nettype wire
